### rtl/core/assert_macros.svh
// Assertion macros for the decoder RTL.
// Included by name from the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define SRPD_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("srpd assertion failed");

// Condition a implies condition b on the following edge.
`define SRPD_ASSERT_NEXT(name, clk, rstn, a, b) \
    name: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("srpd assertion failed");

`endif

### rtl/core/srpd_pkg.sv
// Shared constants, types and the field decode function of the packet decoder.
// No dependencies; used by every module of the block but srpd_ram.
package srpd_pkg;

    localparam int MAX_DEVICES_DEF = 8;
    localparam int KEEP_BYTES      = 30;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [5:0] POS_IDLE     = 6'd0;
    localparam logic [5:0] POS_FIRST    = 6'd1;
    localparam logic [5:0] POS_LAST_SUM = 6'd30;
    localparam logic [5:0] POS_CHECK    = 6'd31;
    localparam logic [5:0] POS_FINAL    = 6'd32;
    localparam logic [5:0] POS_DONE     = 6'd33;

    localparam logic [31:0] TIMEOUT_RST = 32'd5000;
    localparam logic [3:0]  PROTO_RST   = 4'd3;
    localparam logic [3:0]  PROTO_AVG   = 4'd3;

    localparam logic        REG_TIMEOUT = 1'b0;
    localparam logic        REG_PROTO   = 1'b1;

    localparam logic [18:0] BATT_BASE = 19'd2000;
    localparam logic [18:0] BATT_STEP = 19'd10;

    localparam logic [4:0] KIND_DATA_ID  = 5'd0;
    localparam logic [4:0] KIND_BATTERY  = 5'd1;
    localparam logic [4:0] KIND_SPEC0    = 5'd2;
    localparam logic [4:0] KIND_SPEC1    = 5'd3;
    localparam logic [4:0] KIND_SPEC2    = 5'd4;
    localparam logic [4:0] KIND_SPEC3    = 5'd5;
    localparam logic [4:0] KIND_MUSCLE   = 5'd6;
    localparam logic [4:0] KIND_MOMENT   = 5'd7;
    localparam logic [4:0] KIND_QUAT_W   = 5'd8;
    localparam logic [4:0] KIND_QUAT_X   = 5'd9;
    localparam logic [4:0] KIND_QUAT_Y   = 5'd10;
    localparam logic [4:0] KIND_QUAT_Z   = 5'd11;
    localparam logic [4:0] KIND_RAW0     = 5'd12;
    localparam logic [4:0] KIND_RAW1     = 5'd13;
    localparam logic [4:0] KIND_LAST     = 5'd19;

    typedef struct packed {
        logic [KEEP_BYTES-1:0][7:0] bytes;
        logic [31:0]                now_ms;
    } pkt_desc_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

    function automatic logic [18:0] sext16(input logic [15:0] x);
        return {{3{x[15]}}, x};
    endfunction

    function automatic logic [18:0] decode_field(input logic [KEEP_BYTES-1:0][7:0] p,
                                                 input logic [4:0] kind,
                                                 input logic [3:0] proto);
        logic [15:0] spec2;
        logic [15:0] spec3;
        logic [18:0] moment;
        logic [15:0] square;
        logic [15:0] raw0;
        logic [15:0] rawk;
        logic [2:0]  k;
        logic [7:0]  delta;
        logic [18:0] v;
        spec2  = {p[11], p[12]};
        spec3  = {p[13], p[14]};
        moment = {3'b0, spec2} + {2'b0, spec3, 1'b0};
        square = {8'b0, p[8]} * {8'b0, p[8]};
        raw0   = {p[20], p[21]};
        k      = 3'(kind - KIND_RAW1);
        delta  = p[5'd22 + 5'(k)];
        rawk   = p[29][3'(3'd6 - k)] ? (raw0 - {8'b0, delta}) : (raw0 + {8'b0, delta});
        case (kind)
            KIND_DATA_ID: v = {11'b0, p[0]};
            KIND_BATTERY: v = BATT_BASE + {11'b0, p[6]} * BATT_STEP;
            KIND_SPEC0:   v = {3'b0, p[7], 8'b0};
            KIND_SPEC1:   v = {3'b0, p[9], p[10]};
            KIND_SPEC2:   v = {3'b0, spec2};
            KIND_SPEC3:   v = {3'b0, spec3};
            KIND_MUSCLE:  v = (proto < PROTO_AVG) ? moment : {6'b0, square[15:3]};
            KIND_MOMENT:  v = moment;
            KIND_QUAT_W:  v = sext16({p[15], p[16]});
            KIND_QUAT_X:  v = sext16({p[17], 8'b0});
            KIND_QUAT_Y:  v = sext16({p[18], 8'b0});
            KIND_QUAT_Z:  v = sext16({p[19], 8'b0});
            KIND_RAW0:    v = sext16(raw0);
            default:      v = (kind > KIND_RAW0 && kind <= KIND_LAST) ? sext16(rawk) : '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/srpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srpd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/srpd_front.sv
// Byte capture: position tracking, checksum and payload assembly.
// Depends on srpd_pkg; hands finished good packets to the queue.
module srpd_front
    import srpd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic [39:0] s_tdata,   // data_byte [7:0], now_ms [39:8]
    input  logic      s_tuser,     // packet_start
    input  q_status_t q_status,
    output logic      push,
    output pkt_desc_t push_desc
);

    logic [5:0]                 pos_reg;
    logic [7:0]                 sum_reg;
    logic                       good_reg;
    logic [KEEP_BYTES-1:0][7:0] buf_reg;
    logic                       accept;
    logic                       in_packet;
    logic [7:0]                 data_byte;

    assign data_byte = s_tdata[7:0];
    assign s_tready  = !q_status.full;
    assign accept    = s_tvalid && s_tready;
    assign in_packet = (pos_reg != POS_IDLE) && (pos_reg < POS_DONE);
    assign push      = accept && !s_tuser && (pos_reg == POS_FINAL) && good_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= POS_IDLE;
            sum_reg  <= '0;
            good_reg <= 1'b0;
        end else if (accept) begin
            if (s_tuser) begin
                pos_reg <= POS_FIRST;
                sum_reg <= '0;
            end else if (in_packet) begin
                if (pos_reg <= POS_LAST_SUM) begin
                    sum_reg <= sum_reg + data_byte;
                end
                if (pos_reg == POS_CHECK) begin
                    good_reg <= (sum_reg == data_byte);
                end
                pos_reg <= pos_reg + 6'd1;
            end
        end
    end

    // Shift payload in so byte 1 of the packet ends at the bottom.
    always_ff @(posedge aclk) begin
        if (accept && !s_tuser && in_packet && pos_reg <= POS_LAST_SUM) begin
            buf_reg <= {data_byte, buf_reg[KEEP_BYTES-1:1]};
        end
    end

    assign push_desc.bytes  = buf_reg;
    assign push_desc.now_ms = s_tdata[39:8];

endmodule

### rtl/core/srpd_queue.sv
// Short FIFO of checked packets between capture and table/emit logic.
// Depends on srpd_pkg.
module srpd_queue
    import srpd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  pkt_desc_t push_desc,
    input  logic      pop,
    output q_status_t q_status,
    output pkt_desc_t head_desc
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pkt_desc_t       entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign q_status.valid = (count_reg != '0);
    assign q_status.full  = (count_reg == CW'(DEPTH));
    assign head_desc      = entry_reg[rd_ptr_reg];

endmodule

### rtl/core/srpd_back.sv
// Device table walk (evict, find, add) and emission of the 20 field results.
// Depends on srpd_pkg, srpd_ram and assert_macros.svh.
`include "assert_macros.svh"
module srpd_back
    import srpd_pkg::*;
#(
    parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  q_status_t   q_status,
    input  pkt_desc_t   head_desc,
    output logic        pop,
    input  logic [31:0] stale_timeout_ms,
    input  logic [3:0]  proto_sel,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // device_slot [2:0], device_ident [34:3],
                                   // field_kind [39:35], field_value [58:40]
    output logic        m_tlast
);

    localparam int IW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int CW = $clog2(MAX_DEVICES + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_PLACE = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]    state_reg;
    logic [CW-1:0] rd_reg;
    logic [CW-1:0] wr_reg;
    logic [CW-1:0] total_reg;
    logic          found_reg;
    logic [IW-1:0] slot_reg;
    logic [4:0]    kind_reg;
    pkt_desc_t     desc_reg;
    logic          m_valid_reg;
    logic [63:0]   m_data_reg;
    logic          m_last_reg;

    logic [31:0]   ident;
    logic [63:0]   rdata;
    logic [31:0]   ent_id;
    logic [31:0]   ent_time;
    logic          stale;
    logic          match;
    logic          room;
    logic          we;
    logic [IW-1:0] waddr;
    logic [63:0]   wdata;
    logic          out_load;
    logic [18:0]   value;

    assign ident    = {desc_reg.bytes[2], desc_reg.bytes[3], desc_reg.bytes[4],
                       desc_reg.bytes[5]};
    assign ent_id   = rdata[63:32];
    assign ent_time = rdata[31:0];
    assign stale    = (desc_reg.now_ms - ent_time) > stale_timeout_ms;
    assign match    = !found_reg && (ent_id == ident);
    assign room     = (wr_reg < CW'(MAX_DEVICES));
    assign pop      = (state_reg == ST_IDLE) && q_status.valid;
    assign out_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);
    assign value    = decode_field(desc_reg.bytes, kind_reg, proto_sel);

    // Compacting write: kept entries slide down to the write index; a new device is added after them.
    always_comb begin
        we    = 1'b0;
        waddr = wr_reg[IW-1:0];
        wdata = {ident, desc_reg.now_ms};
        case (state_reg)
            ST_CHECK: begin
                we    = !stale;
                wdata = {ent_id, match ? desc_reg.now_ms : ent_time};
            end
            ST_PLACE: begin
                we = !found_reg && room;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    srpd_ram #(
        .WIDTH (64),
        .DEPTH (MAX_DEVICES)
    ) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_reg[IW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_reg      <= '0;
            wr_reg      <= '0;
            total_reg   <= '0;
            found_reg   <= 1'b0;
            kind_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (q_status.valid) begin
                        rd_reg    <= '0;
                        wr_reg    <= '0;
                        found_reg <= 1'b0;
                        state_reg <= (total_reg != '0) ? ST_READ : ST_PLACE;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (!stale) begin
                        wr_reg <= wr_reg + CW'(1);
                        if (match) begin
                            found_reg <= 1'b1;
                        end
                    end
                    rd_reg    <= rd_reg + CW'(1);
                    state_reg <= (rd_reg + CW'(1) == total_reg) ? ST_PLACE : ST_READ;
                end
                ST_PLACE: begin
                    total_reg <= (!found_reg && room) ? wr_reg + CW'(1) : wr_reg;
                    kind_reg  <= KIND_DATA_ID;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_load) begin
                        kind_reg <= kind_reg + 5'd1;
                        if (kind_reg == KIND_LAST) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            desc_reg <= head_desc;
        end
        if (state_reg == ST_CHECK && !stale && match) begin
            slot_reg <= wr_reg[IW-1:0];
        end
        if (state_reg == ST_PLACE && !found_reg) begin
            slot_reg <= room ? wr_reg[IW-1:0] : IW'(MAX_DEVICES - 1);
        end
        if (out_load) begin
            m_data_reg <= {5'b0, value, kind_reg, ident, 3'(slot_reg)};
            m_last_reg <= (kind_reg == KIND_LAST);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `SRPD_ASSERT(a_total_bound, aclk, aresetn, total_reg <= CW'(MAX_DEVICES))
    `SRPD_ASSERT(a_last_kind, aclk, aresetn,
                 !m_tvalid || (m_tlast == (m_tdata[39:35] == KIND_LAST)))
    `SRPD_ASSERT_NEXT(a_pop_walks, aclk, aresetn, pop,
                      state_reg == ST_READ || state_reg == ST_PLACE)

endmodule

### rtl/core/sensor_radio_packet_decoder_top.sv
// Top level of the sensor radio packet decoder: APB registers and channel wiring.
// Depends on srpd_pkg, srpd_front, srpd_queue and srpd_back.
//
// Usage:
//   Input stream (s_*): one packet byte per transfer; s_tuser high marks byte 0
//   of a 33-byte packet. Bytes outside a started packet are dropped.
//   Result stream (m_*): a good packet gives 20 transfers, one per decoded field,
//   m_tlast on the last; a packet with a bad checksum gives none.
//   APB: stale timeout at 0x0, protocol select at 0x4; write only when idle.
// Timing:
//   Capture takes a byte whenever s_tready is high. After the final byte of a
//   good packet the table walk reads and checks each stored device, its read step
//   set by the registered read of the device table RAM, then places the device;
//   results then leave at one per cycle while m_tready is high.
//   A two-entry packet queue separates capture and walk/emit; s_tready falls only
//   when both entries are waiting, so a stalled receiver holds results in the
//   output register while capture continues.
// Reset: aresetn clears position, checksum, queue, device count and the
//   registers to timeout 5000 ms and protocol version 3.
module sensor_radio_packet_decoder_top
    import srpd_pkg::*;
#(
    parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte [7:0], now_ms [39:8]
    input  logic        s_tuser,   // packet_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // device_slot [2:0], device_ident [34:3],
                                   // field_kind [39:35], field_value [58:40]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] timeout_reg;
    logic [3:0]  proto_reg;
    logic        cfg_write;
    q_status_t   q_status;
    logic        push;
    logic        pop;
    pkt_desc_t   push_desc;
    pkt_desc_t   head_desc;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RST;
            proto_reg   <= PROTO_RST;
        end else if (cfg_write) begin
            if (paddr[2] == REG_TIMEOUT) begin
                timeout_reg <= pwdata;
            end else begin
                proto_reg <= pwdata[3:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_PROTO) ? {28'b0, proto_reg} : timeout_reg;

    srpd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_status  (q_status),
        .push      (push),
        .push_desc (push_desc)
    );

    srpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .q_status  (q_status),
        .head_desc (head_desc)
    );

    srpd_back #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_status         (q_status),
        .head_desc        (head_desc),
        .pop              (pop),
        .stale_timeout_ms (timeout_reg),
        .proto_sel        (proto_reg),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast)
    );

endmodule

### bench/tb_sensor_radio_packet_decoder_top.sv
// Self-checking bench for sensor_radio_packet_decoder_top: streams packets and stray
// bytes, predicts the 20 decoded fields per good packet, and compares them.
// Depends on srpd_pkg and the decoder RTL.
module tb_sensor_radio_packet_decoder_top;
    import srpd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        start;
        logic [31:0] now_ms;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  slot;
        logic [31:0] ident;
        logic [4:0]  kind;
        logic [18:0] value;
        logic        last;
    } field_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sensor_radio_packet_decoder_top dut (.*);

    // Predictor state
    logic [31:0] timeout_ms;
    logic [3:0]  proto_ver;
    logic [7:0]  pay [32];
    int          pos;
    logic [7:0]  csum;
    logic [31:0] ids [8];
    logic [31:0] seen [8];
    int          dev_count;

    byte_item_t  pending_bytes[$];
    field_t      expected_fields[$];
    int          errors;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_sender;
    logic [31:0] clock_ms;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("sensor_radio_packet_decoder_top: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %s got %0h want %0h", what, got, want);
        errors++;
    endtask

    function automatic logic [18:0] s16(input logic [15:0] v);
        return {{3{v[15]}}, v};
    endfunction

    function automatic int lookup_device(input logic [31:0] ident, input logic [31:0] now);
        int w;
        w = 0;
        for (int r = 0; r < dev_count; r++) begin
            if (now - seen[r] <= timeout_ms) begin
                ids[w] = ids[r];
                seen[w] = seen[r];
                w++;
            end
        end
        dev_count = w;
        for (int i = 0; i < dev_count; i++) begin
            if (ids[i] == ident) begin
                seen[i] = now;
                return i;
            end
        end
        if (dev_count < 8) begin
            ids[dev_count] = ident;
            seen[dev_count] = now;
            dev_count++;
        end
        return dev_count - 1;
    endfunction

    // Advance the predictor by one accepted byte.
    function automatic void decode_byte(input byte_item_t it);
        logic [31:0] ident;
        logic [18:0] v [20];
        logic [15:0] spec2, spec3, raw0;
        int slot;
        field_t f;
        if (it.start) begin
            pos = 1;
            csum = 8'd0;
            return;
        end
        if (pos == 0 || pos >= 33) return;
        pay[pos-1] = it.data_byte;
        if (pos <= 30) csum = csum + it.data_byte;
        pos++;
        if (pos != 33 || csum != pay[30]) return;
        ident = {pay[2], pay[3], pay[4], pay[5]};
        slot = lookup_device(ident, it.now_ms);
        spec2 = {pay[11], pay[12]};
        spec3 = {pay[13], pay[14]};
        raw0 = {pay[20], pay[21]};
        v[0] = {11'b0, pay[0]};
        v[1] = 19'd2000 + 19'd10 * pay[6];
        v[2] = {3'b0, pay[7], 8'b0};
        v[3] = {3'b0, pay[9], pay[10]};
        v[4] = {3'b0, spec2};
        v[5] = {3'b0, spec3};
        v[7] = {3'b0, spec2} + {2'b0, spec3, 1'b0};
        v[6] = (proto_ver < 4'd3) ? v[7] :
               19'(({8'b0, pay[8]} * {8'b0, pay[8]}) >> 3);
        v[8] = s16({pay[15], pay[16]});
        v[9] = s16({pay[17], 8'b0});
        v[10] = s16({pay[18], 8'b0});
        v[11] = s16({pay[19], 8'b0});
        v[12] = s16(raw0);
        for (int k = 0; k < 7; k++)
            v[13+k] = s16(pay[29][6-k] ? raw0 - pay[22+k] : raw0 + pay[22+k]);
        for (int k = 0; k < 20; k++) begin
            f.slot = 3'(slot);
            f.ident = ident;
            f.kind = 5'(k);
            f.value = v[k];
            f.last = (k == 19);
            expected_fields.push_back(f);
        end
    endfunction

    // Driver: present the head of the queue, advance on transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid) void'(pending_bytes.pop_front());
            if (pending_bytes.size() > 0 && hold_sender == 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                byte_item_t nx;
                nx = pending_bytes[0];
                s_tvalid <= 1'b1;
                s_tdata <= {nx.now_ms, nx.data_byte};
                s_tuser <= nx.start;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Mirror prediction on the accept edge.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            decode_byte('{s_tdata[7:0], s_tuser, s_tdata[39:8]});
    end

    // Monitor: compare results against the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_fields.size() == 0) begin
                    report_mismatch("unexpected result kind", 32'(m_tdata[39:35]), 32'd0);
                end else begin
                    field_t e;
                    e = expected_fields.pop_front();
                    if (m_tdata[2:0] != e.slot)
                        report_mismatch("slot", 32'(m_tdata[2:0]), 32'(e.slot));
                    if (m_tdata[34:3] != e.ident)
                        report_mismatch("ident", m_tdata[34:3], e.ident);
                    if (m_tdata[39:35] != e.kind)
                        report_mismatch("kind", 32'(m_tdata[39:35]), 32'(e.kind));
                    if (m_tdata[58:40] != e.value)
                        report_mismatch("value", 32'(m_tdata[58:40]), 32'(e.value));
                    if (m_tlast != e.last)
                        report_mismatch("last", 32'(m_tlast), 32'(e.last));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 3'd0) timeout_ms = data;
        else proto_ver = data[3:0];
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || s_tvalid || expected_fields.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic void queue_byte(input logic [7:0] b, input logic st);
        pending_bytes.push_back('{b, st, clock_ms});
    endfunction

    // Build one packet; ids drawn from a small pool so the table fills and ages.
    task automatic queue_packet(input bit good, input int id_sel, input int step_ms,
                                input bit extreme);
        logic [7:0] p [32];
        logic [7:0] s;
        clock_ms = clock_ms + step_ms;
        s = 8'd0;
        for (int i = 0; i < 32; i++)
            p[i] = extreme ? (id_sel[0] ? 8'hFF : 8'h00) : 8'($urandom);
        if (id_sel >= 0) {p[2], p[3], p[4], p[5]} = 32'hA5000000 + id_sel;
        for (int i = 0; i < 30; i++) s = s + p[i];
        p[30] = good ? s : s + 8'd1 + 8'($urandom_range(254));
        queue_byte(8'($urandom), 1'b1);
        for (int i = 0; i < 32; i++) queue_byte(p[i], 1'b0);
    endtask

    initial begin
        errors = 0; pos = 0; csum = 0; dev_count = 0;
        timeout_ms = 32'd5000; proto_ver = 4'd3; clock_ms = 32'hFFFF_FF80;
        hold_sender = 1; send_idle_pct = 10; recv_idle_pct = 68;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0; m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        // Sender idles 10%, receiver 68%: stray bytes, bad sum, restart,
        // extremes and table overflow across the time wrap.
        queue_byte(8'h5A, 1'b0);
        queue_packet(0, 2, 100, 0);
        queue_byte(8'h11, 1'b0);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h22, 1'b0);
        for (int i = 0; i < 9; i++) queue_packet(1, i, 10, i < 2);
        hold_sender = 0;
        // Wait until every queued byte is sent and every expected result has come.
        wait_drained();
        // Sender idles 68%, receiver 10%: zero timeout evicts every entry older than the new packet.
        send_idle_pct = 68; recv_idle_pct = 10;
        apb_write(3'd4, 32'd0);
        apb_write(3'd0, 32'd0);
        queue_packet(1, 3, 0, 0);
        wait_drained();
        // Neither side idles; nothing ages out.
        send_idle_pct = 0; recv_idle_pct = 0;
        apb_write(3'd0, 32'hFFFF_FFFF);
        apb_write(3'd4, 32'd15);
        queue_packet(1, 9, 3000, 0);
        wait_drained();
        if (errors == 0)
            $display("sensor_radio_packet_decoder_top: match");
        else
            $display("sensor_radio_packet_decoder_top: mismatch");
        $finish;
    end
endmodule
